FILE: rtl/core/afc_pkg.sv
// Shared types and constants for the autorange frequency counter.
// Used by the binary-to-BCD converter and the top level; no dependencies.

package afc_pkg;

    localparam int FREQ_W     = 32;   // binary frequency width
    localparam int BCD_DIGITS = 10;   // decimal digits needed for a 32-bit value
    localparam int OUT_NIBS   = 8;    // BCD nibbles that fit the digits field
    localparam int EDGE_W     = 30;   // saturating edge total
    localparam int TICK_W     = 17;   // gate length and tick position
    localparam int IN_EDGE_W  = 10;   // edges per reference tick

    localparam logic [EDGE_W-1:0] EDGE_MAX = {EDGE_W{1'b1}};

    // register map, index = paddr[3:2]
    localparam logic [1:0] REG_LONG_GATE = 2'd0;
    localparam logic [1:0] REG_LOW_THR   = 2'd1;
    localparam logic [1:0] REG_HIGH_THR  = 2'd2;

    localparam logic [TICK_W-1:0] LONG_GATE_RST = 17'd32768;
    localparam logic [FREQ_W-1:0] LOW_THR_RST   = 32'd800000;
    localparam logic [FREQ_W-1:0] HIGH_THR_RST  = 32'd900000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DECIDE,
        ST_CONV,
        ST_SEND
    } afc_state_t;

    typedef struct packed {
        logic              start;
        logic [FREQ_W-1:0] value;
    } conv_req_t;

    typedef struct packed {
        logic                    done;
        logic [4*BCD_DIGITS-1:0] bcd;
    } conv_rsp_t;

endpackage

FILE: rtl/core/afc_bcd_conv.sv
// Iterative binary-to-BCD converter (shift and add-3), one bit per cycle.
// Depends on afc_pkg for widths and the request/response structs.

module afc_bcd_conv (
    input  logic               aclk,
    input  logic               aresetn,
    input  afc_pkg::conv_req_t req,
    output afc_pkg::conv_rsp_t rsp
);
    import afc_pkg::*;

    localparam int CNT_W = $clog2(FREQ_W + 1);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [FREQ_W-1:0]       bin_reg, bin_next;
    logic [4*BCD_DIGITS-1:0] bcd_reg, bcd_next;
    logic [4*BCD_DIGITS-1:0] adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < BCD_DIGITS; d++) begin
            if (bcd_reg[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            end else begin
                adj[4*d +: 4] = bcd_reg[4*d +: 4];
            end
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(FREQ_W);
            bin_next  = req.value;
            bcd_next  = '0;
        end else if (busy_reg) begin
            bcd_next = {adj[4*BCD_DIGITS-2:0], bin_reg[FREQ_W-1]};
            bin_next = {bin_reg[FREQ_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign rsp.done = done_reg;
    assign rsp.bcd  = bcd_reg;

endmodule

FILE: rtl/core/autorange_frequency_counter_unit.sv
// Gated frequency counter with automatic long/short gate selection.
// Depends on afc_pkg and instantiates afc_bcd_conv.
//
// Usage:
//   s_ channel: one transaction per reference tick, s_tdata[9:0] = edges seen.
//   m_ channel: one transaction on the tick that closes a gate, carrying the
//     frequency, its BCD digits and blank mask, and the gate/over-range flags.
//   APB port: 0x0 long gate ticks, 0x4 low threshold, 0x8 high threshold.
//     Write only while no tick is in flight.
// Sequence:
//   A tick that does not close a gate is accepted, then accumulated.
//   A closing tick is accepted, accumulated, compared with the thresholds,
//   run through the bit-serial BCD converter (32 shifts, one per cycle, then
//   its done flag), and loaded into the output register once that is free.
//   s_tready is low meanwhile.
// Reset: short gate first, empty total, register reset values loaded.
// Stall: a pending result sits in the output register; the block keeps taking
//   ticks until a further gate closes, then holds that result, with s_tready low, until the receiver takes the first.

module autorange_frequency_counter_unit #(
    parameter int DIGITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] edges_in_tick
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [31:0] frequency, [63:32] digits_bcd, [71:64] blank_mask
    output logic [1:0]  m_tuser,   // [0] used_short_gate, [1] over_range
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import afc_pkg::*;

    localparam int KEPT_DIGITS = (DIGITS < OUT_NIBS) ? DIGITS : OUT_NIBS;

    afc_state_t state_reg, state_next;

    logic [TICK_W-1:0] long_gate_reg;
    logic [FREQ_W-1:0] low_thr_reg;
    logic [FREQ_W-1:0] high_thr_reg;

    logic [EDGE_W-1:0]    edge_total_reg, edge_total_next;
    logic [TICK_W-1:0]    tick_pos_reg, tick_pos_next;
    logic                 short_mode_reg, short_mode_next;
    logic                 used_short_reg, used_short_next;
    logic [IN_EDGE_W-1:0] edges_reg;
    logic [FREQ_W-1:0]    freq_reg, freq_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [71:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;
    logic        out_load;

    logic [EDGE_W:0]   sum;
    logic [EDGE_W-1:0] sat_total;
    logic [TICK_W-1:0] gate_len_raw, gate_len;
    logic [TICK_W:0]   ticks;
    logic              gate_close;

    logic [4*OUT_NIBS-1:0] digits;
    logic [OUT_NIBS-1:0]   blank;
    logic                  over;
    logic                  hi_zero;

    logic      cfg_wr;
    conv_req_t conv_req;
    conv_rsp_t conv_rsp;

    afc_bcd_conv u_conv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (conv_req),
        .rsp     (conv_rsp)
    );

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_gate_reg <= LONG_GATE_RST;
            low_thr_reg   <= LOW_THR_RST;
            high_thr_reg  <= HIGH_THR_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_LONG_GATE: long_gate_reg <= pwdata[TICK_W-1:0];
                REG_LOW_THR:   low_thr_reg   <= pwdata;
                REG_HIGH_THR:  high_thr_reg  <= pwdata;
                default:       ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_LONG_GATE: prdata = {{(32-TICK_W){1'b0}}, long_gate_reg};
            REG_LOW_THR:   prdata = low_thr_reg;
            REG_HIGH_THR:  prdata = high_thr_reg;
            default:       prdata = '0;
        endcase
    end

    // saturating accumulate and gate end check
    assign sum          = {1'b0, edge_total_reg} + (EDGE_W+1)'(edges_reg);
    assign sat_total    = sum[EDGE_W] ? EDGE_MAX : sum[EDGE_W-1:0];
    assign gate_len_raw = short_mode_reg ? (long_gate_reg >> 2) : long_gate_reg;
    assign gate_len     = (gate_len_raw == '0) ? TICK_W'(1) : gate_len_raw;
    assign ticks        = {1'b0, tick_pos_reg} + (TICK_W+1)'(1);
    assign gate_close   = ticks >= {1'b0, gate_len};

    assign s_tready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_SEND) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next      = state_reg;
        edge_total_next = edge_total_reg;
        tick_pos_next   = tick_pos_reg;
        short_mode_next = short_mode_reg;
        used_short_next = used_short_reg;
        freq_next       = freq_reg;
        conv_req.start  = 1'b0;
        conv_req.value  = freq_reg;
        m_tvalid_next   = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                if (gate_close) begin
                    freq_next       = short_mode_reg ? {sat_total, 2'b00}
                                                     : {2'b00, sat_total};
                    used_short_next = short_mode_reg;
                    edge_total_next = '0;
                    tick_pos_next   = '0;
                    state_next      = ST_DECIDE;
                end else begin
                    edge_total_next = sat_total;
                    tick_pos_next   = ticks[TICK_W-1:0];
                    state_next      = ST_IDLE;
                end
            end
            ST_DECIDE: begin
                // hysteresis on the next gate, then kick off the conversion
                if (short_mode_reg && (freq_reg < low_thr_reg)) begin
                    short_mode_next = 1'b0;
                end else if (!short_mode_reg && (freq_reg > high_thr_reg)) begin
                    short_mode_next = 1'b1;
                end
                conv_req.start = 1'b1;
                state_next     = ST_CONV;
            end
            ST_CONV: begin
                if (conv_rsp.done) begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            edge_total_reg <= '0;
            tick_pos_reg   <= '0;
            short_mode_reg <= 1'b1;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            edge_total_reg <= edge_total_next;
            tick_pos_reg   <= tick_pos_next;
            short_mode_reg <= short_mode_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // digits, leading-zero mask and over-range from the full ten-digit result
    always_comb begin
        digits  = '0;
        blank   = '0;
        over    = 1'b0;
        hi_zero = 1'b1;
        for (int i = 0; i < KEPT_DIGITS; i++) begin
            digits[4*i +: 4] = conv_rsp.bcd[4*i +: 4];
        end
        for (int i = 1; i < KEPT_DIGITS; i++) begin
            hi_zero = 1'b1;
            for (int j = 0; j < BCD_DIGITS; j++) begin
                if ((j >= i) && (conv_rsp.bcd[4*j +: 4] != 4'd0)) begin
                    hi_zero = 1'b0;
                end
            end
            blank[i] = hi_zero;
        end
        for (int j = 0; j < BCD_DIGITS; j++) begin
            if ((j >= DIGITS) && (conv_rsp.bcd[4*j +: 4] != 4'd0)) begin
                over = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            edges_reg <= s_tdata[IN_EDGE_W-1:0];
        end
        freq_reg       <= freq_next;
        used_short_reg <= used_short_next;
        if (out_load) begin
            m_tdata_reg <= {blank, digits, freq_reg};
            m_tuser_reg <= {over, used_short_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: tb/afc_reading_checker.sv
// Reading checker for the autorange frequency counter: follows register writes
// and input ticks, predicts every gate reading and compares the m_ channel.
// Depends on afc_pkg; instantiated beside the block by the testbench top.

module afc_reading_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] edges_in_tick
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,   // [31:0] frequency, [63:32] digits_bcd, [71:64] blank_mask
    input  logic [1:0]  m_tuser,   // [0] used_short_gate, [1] over_range
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import afc_pkg::*;

    localparam int DISPLAY_DIGITS = 8;

    typedef struct packed {
        logic [FREQ_W-1:0] frequency;
        logic [31:0]       digits_bcd;
        logic [7:0]        blank_mask;
        logic              used_short_gate;
        logic              over_range;
    } reading_t;

    // register copies
    logic [TICK_W-1:0] long_gate;
    logic [FREQ_W-1:0] low_thr;
    logic [FREQ_W-1:0] high_thr;

    // gate state
    logic [EDGE_W-1:0] edge_sum;
    logic [TICK_W-1:0] tick_pos;
    logic              short_mode;

    reading_t          readings_due[$];
    int                errors = 0;

    function automatic logic [TICK_W-1:0] gate_ticks();
        logic [TICK_W-1:0] len;
        len = short_mode ? (long_gate >> 2) : long_gate;
        return (len == '0) ? TICK_W'(1) : len;
    endfunction

    function automatic reading_t make_reading(input logic [FREQ_W-1:0] freq,
                                              input logic short_gate);
        reading_t    r;
        logic [63:0] rest;
        logic [63:0] limit;
        logic [63:0] digit;
        int          i;
        r                 = '0;
        r.frequency       = freq;
        r.used_short_gate = short_gate;
        rest              = 64'(freq);
        limit             = 64'd1;
        for (i = 0; i < DISPLAY_DIGITS; i++) begin
            digit = rest % 10;
            if (i < 8) begin
                r.digits_bcd[4*i +: 4] = digit[3:0];
                // digit 0 always shows, so zero reads as a single 0
                if (i > 0 && rest == 0)
                    r.blank_mask[i] = 1'b1;
            end
            rest  = rest / 10;
            limit = limit * 10;
        end
        r.over_range = (64'(freq) >= limit);
        return r;
    endfunction

    task automatic count_tick(input logic [IN_EDGE_W-1:0] edges);
        logic [TICK_W:0]   ticks;
        logic [FREQ_W-1:0] freq;
        // saturate instead of wrapping
        if (edge_sum > EDGE_MAX - EDGE_W'(edges))
            edge_sum = EDGE_MAX;
        else
            edge_sum = edge_sum + EDGE_W'(edges);
        ticks = {1'b0, tick_pos} + 1'b1;
        if (ticks < {1'b0, gate_ticks()}) begin
            tick_pos = ticks[TICK_W-1:0];
        end else begin
            freq = short_mode ? {edge_sum, 2'b00} : {2'b00, edge_sum};
            readings_due.push_back(make_reading(freq, short_mode));
            // hysteresis: only a strict crossing changes the gate
            if (short_mode) begin
                if (freq < low_thr)
                    short_mode = 1'b0;
            end else if (freq > high_thr) begin
                short_mode = 1'b1;
            end
            edge_sum = '0;
            tick_pos = '0;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        reading_t want;
        if (!aresetn) begin
            long_gate  = LONG_GATE_RST;
            low_thr    = LOW_THR_RST;
            high_thr   = HIGH_THR_RST;
            edge_sum   = '0;
            tick_pos   = '0;
            short_mode = 1'b1;
            readings_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_LONG_GATE: long_gate = pwdata[TICK_W-1:0];
                    REG_LOW_THR:   low_thr   = pwdata;
                    REG_HIGH_THR:  high_thr  = pwdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                count_tick(s_tdata[IN_EDGE_W-1:0]);
            if (m_tvalid && m_tready) begin
                if (readings_due.size() == 0) begin
                    $error("reading with none expected: frequency 0x%0h", m_tdata[31:0]);
                    errors++;
                end else begin
                    want = readings_due.pop_front();
                    check_field("frequency", want.frequency, m_tdata[31:0]);
                    check_field("digits_bcd", want.digits_bcd, m_tdata[63:32]);
                    check_field("blank_mask", 32'(want.blank_mask), 32'(m_tdata[71:64]));
                    check_field("used_short_gate", 32'(want.used_short_gate),
                                32'(m_tuser[0]));
                    check_field("over_range", 32'(want.over_range), 32'(m_tuser[1]));
                end
            end
        end
        pending    <= readings_due.size();
        fail_count <= errors;
    end

endmodule

FILE: tb/tb_autorange_frequency_counter_unit.sv
// Testbench top for autorange_frequency_counter_unit: drives reset, ticks,
// receiver stalls and APB writes; the reading checker does all comparing.
// Depends on afc_pkg, the block and afc_reading_checker.

module tb_autorange_frequency_counter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import afc_pkg::*;

    localparam int         SETTLE_CYCLES   = 48;
    localparam int         STALL_LIMIT     = 2000;
    localparam int         RANDOM_PHASES   = 6;
    localparam int         TICKS_PER_PHASE = 64;
    localparam logic [1:0] REG_SPARE       = 2'd3;   // decodes to no register

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // [9:0] edges_in_tick
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;           // [31:0] frequency, [63:32] digits_bcd, [71:64] blank_mask
    logic [1:0]  m_tuser;           // [0] used_short_gate, [1] over_range
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          tx_idle_pct = 35;
    int          rx_idle_pct = 50;
    int          quiet_cycles = 0;

    autorange_frequency_counter_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    afc_reading_checker readings (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // abort when no transaction of any kind completes for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (psel && penable && pwrite && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [IN_EDGE_W-1:0] random_edges();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return IN_EDGE_W'($urandom_range(15));
            default: return IN_EDGE_W'($urandom);
        endcase
    endfunction

    task automatic push_tick(input logic [IN_EDGE_W-1:0] edges);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(16-IN_EDGE_W){1'b0}}, edges};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // hold the sender until every reading is in, then let the block settle
    task automatic drain(input int settle);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        logic [TICK_W-1:0] gate;
        int                span;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // short gate of 2 ticks first; frequency equal to the low threshold stays short
        write_reg(REG_LONG_GATE, 32'd8);
        write_reg(REG_LOW_THR, 32'd800);
        write_reg(REG_HIGH_THR, 32'd8184);
        push_tick(10'd100);
        push_tick(10'd100);
        // zero reading, drops to the long gate
        push_tick(10'd0);
        push_tick(10'd0);
        // full-scale long gate equal to the high threshold stays long
        repeat (8) push_tick(10'd1023);

        // tiny gates: long gate of 3, short gate rounds down to zero and runs 1 tick
        drain(SETTLE_CYCLES);
        write_reg(REG_HIGH_THR, 32'd0);
        write_reg(REG_LONG_GATE, 32'd3);
        push_tick(10'h2AA);
        push_tick(10'h155);
        push_tick(10'd1);
        push_tick(10'h155);
        push_tick(10'd0);

        drain(SETTLE_CYCLES);
        write_reg(REG_LONG_GATE, 32'd0);
        push_tick(10'd5);
        push_tick(10'd7);

        // long gate of 65536 ticks, then shrink it below the ticks already taken
        drain(SETTLE_CYCLES);
        write_reg(REG_LONG_GATE, 32'h0001_0000);
        write_reg(REG_LOW_THR, 32'hFFFF_FFFF);
        write_reg(REG_HIGH_THR, 32'hFFFF_FFFF);
        write_reg(REG_SPARE, 32'h0000_0005);
        repeat (200) push_tick(random_edges());
        drain(SETTLE_CYCLES);
        write_reg(REG_LONG_GATE, 32'd8);
        push_tick(random_edges());

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            tx_idle_pct = (p < 2) ? 35 : (p < 4) ? 50 : 0;
            rx_idle_pct = (p < 2) ? 50 : (p < 4) ? 35 : 0;
            drain(SETTLE_CYCLES);
            if ($urandom_range(4) == 0)
                gate = TICK_W'($urandom_range(3));
            else
                gate = TICK_W'($urandom_range(40, 4));
            // thresholds around the usual reading so the gate keeps switching
            span = int'(gate) * 600 + 1;
            write_reg(REG_LONG_GATE, 32'(gate));
            write_reg(REG_LOW_THR, $urandom_range(span));
            write_reg(REG_HIGH_THR, $urandom_range(span));
            for (int n = 0; n < TICKS_PER_PHASE; n++) begin
                if ($urandom_range(49) == 0)
                    drain(0);
                push_tick(random_edges());
            end
        end

        drain(SETTLE_CYCLES);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/afc_pkg.sv
rtl/core/afc_bcd_conv.sv
rtl/core/autorange_frequency_counter_unit.sv
tb/afc_reading_checker.sv
tb/tb_autorange_frequency_counter_unit.sv
